// ----- design/esc_pkg.sv -----
// Shared types and constants for the epoch seconds to calendar date core.
// Holds the controller/datapath command and status structs and the month table.
// No dependencies.
package esc_pkg;

    localparam int LOCAL_W = 33;

    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
    localparam logic [3:0]  MONTH_LAST      = 4'd11;
    localparam logic [24:0] YEAR_SECS       = 25'd31536000;
    localparam logic [24:0] LEAP_YEAR_SECS  = 25'd31622400;
    localparam logic [21:0] DAY_SECS        = 22'd86400;
    localparam logic [21:0] HOUR_SECS       = 22'd3600;

    // Scaled reciprocals of 675, 225 and 15; exact over the shifted operand ranges
    localparam logic [15:0] DAY_RECIP       = 16'd49711;
    localparam logic [15:0] HOUR_RECIP      = 16'd9321;
    localparam logic [15:0] MIN_RECIP       = 16'd1093;

    typedef enum logic [1:0] {
        SPLIT_DAY  = 2'd0,
        SPLIT_HOUR = 2'd1,
        SPLIT_MIN  = 2'd2
    } split_sel_t;

    typedef struct packed {
        logic       load;
        logic       year_step;
        logic       month_step;
        logic       quot;
        logic       reduce;
        split_sel_t split_sel;
        logic       emit;
    } esc_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } esc_status_t;

    function automatic logic [21:0] month_secs(input logic [3:0] idx, input logic leap);
        logic [21:0] d;
        unique case (idx)
            4'd1:                    d = leap ? 22'd2505600 : 22'd2419200;
            4'd3, 4'd5, 4'd8, 4'd10: d = 22'd2592000;
            default:                 d = 22'd2678400;
        endcase
        return d;
    endfunction

endpackage

// ----- design/esc_ctrl.sv -----
// Sequencer for the epoch seconds to calendar date core.
// Drives the datapath through year, month and split phases; uses esc_pkg.
module esc_ctrl import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  esc_status_t status,
    output esc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_YEAR   = 6'b000010,
        S_MONTH  = 6'b000100,
        S_QUOT   = 6'b001000,
        S_REDUCE = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    split_sel_t         sel_reg, sel_next;
    logic               m_valid_reg, m_valid_next;

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.split_sel = sel_reg;
        s_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_YEAR;
                end
            end
            S_YEAR: begin
                if (status.year_done) begin
                    state_next = S_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (status.month_done) begin
                    sel_next   = SPLIT_DAY;
                    state_next = S_QUOT;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            S_QUOT: begin
                cmd.quot = 1'b1;
                if (sel_reg == SPLIT_MIN) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                cmd.reduce = 1'b1;
                state_next = S_QUOT;
                if (sel_reg == SPLIT_DAY) begin
                    sel_next = SPLIT_HOUR;
                end else begin
                    sel_next = SPLIT_MIN;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= SPLIT_DAY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- design/esc_datapath.sv -----
// Datapath for the epoch seconds to calendar date core: offset add, year and month
// walkers in seconds, reciprocal-multiply day/hour/minute split, result registers. Uses esc_pkg.
module esc_datapath import esc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic signed [16:0] cfg_wr_data,
    input  logic [31:0]        s_epoch_seconds,
    input  esc_cmd_t           cmd,
    output esc_status_t        status,
    output logic [5:0]         m_minute,
    output logic [4:0]         m_hour,
    output logic [4:0]         m_day_of_month,
    output logic [3:0]         m_month_number,
    output logic [11:0]        m_year_number
);

    logic signed [16:0]  offset_reg;
    logic [LOCAL_W-1:0]  work_reg, work_next;
    logic [5:0]          minute_reg, minute_next;
    logic [4:0]          hour_reg, hour_next;
    logic [4:0]          dom_reg, dom_next;
    logic [11:0]         year_reg, year_next;
    logic [3:0]          mon_reg, mon_next;

    logic [5:0]          minute_out_reg;
    logic [4:0]          hour_out_reg;
    logic [4:0]          day_out_reg;
    logic [3:0]          month_out_reg;
    logic [11:0]         year_out_reg;

    logic signed [LOCAL_W:0] local_sum;
    logic [LOCAL_W-1:0]      local_sat;
    logic                    leap;
    logic [24:0]             year_secs;
    logic [21:0]             cur_secs;
    logic [14:0]             mul_a;
    logic [15:0]             mul_b;
    logic [30:0]             mul_p;
    logic [5:0]              quot;
    logic [21:0]             red_secs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            offset_reg <= cfg_wr_data;
        end
    end

    assign local_sum = $signed({2'b00, s_epoch_seconds})
                     + (LOCAL_W+1)'(offset_reg);
    assign local_sat = local_sum[LOCAL_W] ? '0 : local_sum[LOCAL_W-1:0];

    assign leap      = (year_reg[1:0] == 2'b00) && (year_reg != NONLEAP_CENTURY);
    assign year_secs = leap ? LEAP_YEAR_SECS : YEAR_SECS;
    assign cur_secs  = month_secs(mon_reg, leap);

    assign status.year_done  = work_reg < LOCAL_W'(year_secs);
    assign status.month_done = (mon_reg == MONTH_LAST) || (work_reg < LOCAL_W'(cur_secs));

    always_comb begin
        unique case (cmd.split_sel)
            SPLIT_DAY: begin
                mul_a = work_reg[21:7];
                mul_b = DAY_RECIP;
            end
            SPLIT_HOUR: begin
                mul_a = {2'b00, work_reg[16:4]};
                mul_b = HOUR_RECIP;
            end
            default: begin
                mul_a = {5'b00000, work_reg[11:2]};
                mul_b = MIN_RECIP;
            end
        endcase
    end

    assign mul_p = 31'(mul_a) * 31'(mul_b);

    always_comb begin
        unique case (cmd.split_sel)
            SPLIT_DAY: begin
                quot     = {1'b0, mul_p[29:25]};
                red_secs = 22'(dom_reg) * DAY_SECS;
            end
            SPLIT_HOUR: begin
                quot     = {1'b0, mul_p[25:21]};
                red_secs = 22'(hour_reg) * HOUR_SECS;
            end
            default: begin
                quot     = mul_p[19:14];
                red_secs = '0;
            end
        endcase
    end

    always_comb begin
        work_next   = work_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        dom_next    = dom_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        if (cmd.load) begin
            work_next = local_sat;
            year_next = EPOCH_YEAR;
            mon_next  = '0;
        end
        if (cmd.year_step) begin
            work_next = work_reg - LOCAL_W'(year_secs);
            year_next = year_reg + 12'd1;
        end
        if (cmd.month_step) begin
            work_next = work_reg - LOCAL_W'(cur_secs);
            mon_next  = mon_reg + 4'd1;
        end
        if (cmd.quot) begin
            unique case (cmd.split_sel)
                SPLIT_DAY:  dom_next    = quot[4:0];
                SPLIT_HOUR: hour_next   = quot[4:0];
                default:    minute_next = quot;
            endcase
        end
        if (cmd.reduce) begin
            work_next = work_reg - LOCAL_W'(red_secs);
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        minute_reg <= minute_next;
        hour_reg   <= hour_next;
        dom_reg    <= dom_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        if (cmd.emit) begin
            minute_out_reg <= minute_reg;
            hour_out_reg   <= hour_reg;
            day_out_reg    <= dom_reg + 5'd1;
            month_out_reg  <= mon_reg + 4'd1;
            year_out_reg   <= year_reg;
        end
    end

    assign m_minute       = minute_out_reg;
    assign m_hour         = hour_out_reg;
    assign m_day_of_month = day_out_reg;
    assign m_month_number = month_out_reg;
    assign m_year_number  = year_out_reg;

endmodule

// ----- design/epoch_seconds_to_calendar_date_core.sv -----
// Epoch seconds to local calendar date: top level.
// Instantiates esc_ctrl and esc_datapath; uses esc_pkg.
//
// Usage:
//   The request channel (s_valid/s_ready, s_epoch_seconds) takes an unsigned
//   count of seconds since 1970-01-01 00:00 UTC. The zone offset register
//   (signed seconds, reset 0) is written through cfg_wr_en/cfg_wr_data while
//   the core is idle. Local time below zero saturates to 1970-01-01 00:00.
//   Each request gives one result on the m_ channel: minute, hour, day of
//   month, month and year of local time.
//   After the accept the core walks the years from 1970 (up to 136) and
//   then the months (up to 11), subtracting the seconds of each, splits
//   the rest into day, hour and minute by reciprocal multiplication
//   (quotient and reduce steps in turn) and loads the result register.
//   One request is in work at a time; s_ready is high only when idle.
//   The result register lets a new request start while the previous result
//   waits; if the receiver still stalls when the next result is done, the
//   core holds until the result register frees up.
//   Reset (aresetn low, synchronous) clears the sequencer, the output valid
//   and the zone offset.
module epoch_seconds_to_calendar_date_core import esc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic signed [16:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_epoch_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_minute,
    output logic [4:0]         m_hour,
    output logic [4:0]         m_day_of_month,
    output logic [3:0]         m_month_number,
    output logic [11:0]        m_year_number
);

    esc_cmd_t    cmd;
    esc_status_t status;

    esc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    esc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_epoch_seconds (s_epoch_seconds),
        .cmd             (cmd),
        .status          (status),
        .m_minute        (m_minute),
        .m_hour          (m_hour),
        .m_day_of_month  (m_day_of_month),
        .m_month_number  (m_month_number),
        .m_year_number   (m_year_number)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a request is in work");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_number != 4'd0) && (m_month_number <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_of_month != 5'd0))
        else $error("day of month is zero");

    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour < 5'd24) && (m_minute < 6'd60))
        else $error("hour or minute out of range");

endmodule
